@@ rtl/ssld_pkg.sv @@
package ssld_pkg;

    localparam int MAX_DIGITS_DEF = 8;

    localparam logic [2:0] REQ_SIGN     = 3'd0;
    localparam logic [2:0] REQ_SIGN_DOT = 3'd1;
    localparam logic [2:0] REQ_SIGN_EXP = 3'd2;
    localparam logic [2:0] REQ_DIGIT    = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;
    localparam logic [2:0] REQ_DOTS     = 3'd5;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_AT   = 8'h40;
    localparam logic [7:0] CHAR_LF   = 8'd10;
    localparam logic [7:0] CHAR_SP   = 8'd32;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] sign_char;
        logic       dot_flag;
        logic [7:0] digit_value;
        logic [7:0] dot_mask;
    } t_in_item;

    typedef struct packed {
        logic serial_bit;
        logic latch_pulse;
        logic last;
    } t_out_item;

    typedef enum logic {
        CMD_PUSH,
        CMD_DOTS
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
        logic [2:0] reps;
    } t_cmd;

    function automatic logic [7:0] seg_table(input logic [6:0] idx);
        logic [7:0] v;
        case (idx)
            7'd0:  v = 8'hC8;  7'd1:  v = 8'h0A;  7'd2:  v = 8'h7F;  7'd3:  v = 8'h6E;
            7'd4:  v = 8'h99;  7'd5:  v = 8'h3F;  7'd6:  v = 8'h00;  7'd7:  v = 8'h16;
            7'd8:  v = 8'h4C;  7'd9:  v = 8'h2B;  7'd10: v = 8'h49;  7'd11: v = 8'h40;
            7'd12: v = 8'h01;  7'd13: v = 8'h80;  7'd14: v = 8'h19;  7'd15: v = 8'h7E;
            7'd16: v = 8'h48;  7'd17: v = 8'h3D;  7'd18: v = 8'h6D;  7'd19: v = 8'h4B;
            7'd20: v = 8'h67;  7'd21: v = 8'h77;  7'd22: v = 8'h4C;  7'd23: v = 8'h7F;
            7'd24: v = 8'h6F;  7'd25: v = 8'h81;  7'd26: v = 8'hC0;  7'd27: v = 8'h39;
            7'd28: v = 8'h21;  7'd29: v = 8'h63;  7'd30: v = 8'h9D;  7'd31: v = 8'h5D;
            7'd32: v = 8'h5F;  7'd33: v = 8'h73;  7'd34: v = 8'h31;  7'd35: v = 8'h79;
            7'd36: v = 8'h37;  7'd37: v = 8'h17;  7'd38: v = 8'h76;  7'd39: v = 8'h53;
            7'd40: v = 8'h12;  7'd41: v = 8'h78;  7'd42: v = 8'h3B;  7'd43: v = 8'h32;
            7'd44: v = 8'h5E;  7'd45: v = 8'h51;  7'd46: v = 8'h71;  7'd47: v = 8'h1F;
            7'd48: v = 8'h4F;  7'd49: v = 8'h57;  7'd50: v = 8'h66;  7'd51: v = 8'h4C;
            7'd52: v = 8'h70;  7'd53: v = 8'h2A;  7'd54: v = 8'h7A;  7'd55: v = 8'h5B;
            7'd56: v = 8'h6B;  7'd57: v = 8'h3C;  7'd58: v = 8'h36;  7'd59: v = 8'h43;
            7'd60: v = 8'h6C;  7'd61: v = 8'h0E;  7'd62: v = 8'h20;  7'd63: v = 8'h08;
            7'd64: v = 8'h27;  7'd65: v = 8'h5A;  7'd66: v = 8'h2D;  7'd67: v = 8'h75;
            default: v = 8'h0F;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] seg_code(input logic [7:0] ch);
        logic [7:0] c;
        logic [7:0] inv;
        logic [7:0] v;
        c   = {1'b0, ch[6:0]};
        inv = {ch[7], 7'b0};
        if (c == CHAR_LF || c == CHAR_SP) begin
            v = 8'h00;
        end else if (c < 8'd33) begin
            v = 8'hFF ^ inv;
        end else begin
            if (c > 8'd96) begin
                if (c > 8'd122) begin
                    c = c + 8'd6;
                end
                c = c - 8'd32;
            end
            c = c - 8'd33;
            if (c > 8'd68) begin
                c = 8'd68;
            end
            v = seg_table(c[6:0]) ^ inv;
        end
        return v;
    endfunction

    function automatic logic [63:0] dots_overlay(input logic [63:0] line,
                                                 input logic [7:0] mask);
        logic [63:0] v;
        v = line;
        for (int i = 0; i < 8; i++) begin
            v[8 * i + 7] = mask[i];
        end
        return v;
    endfunction

endpackage

@@ rtl/ssld_front.sv @@
module ssld_front #(
    parameter int MAX_DIGITS = ssld_pkg::MAX_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssld_pkg::t_in_item i_in_item,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output ssld_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] MaxLen = 4'(MAX_DIGITS);

    logic [3:0] r_line_length;
    logic [3:0] len_clamped;
    logic       is_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= 4'd8;
        end else if (i_cfg_we) begin
            r_line_length <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_line_length == 4'd0) begin
            len_clamped = 4'd1;
        end else if (r_line_length > MaxLen) begin
            len_clamped = MaxLen;
        end else begin
            len_clamped = r_line_length;
        end
    end

    always_comb begin
        is_cmd      = 1'b1;
        o_cmd.op    = ssld_pkg::CMD_PUSH;
        o_cmd.data  = 8'h00;
        o_cmd.reps  = 3'd0;
        unique case (i_in_item.req_type)
            ssld_pkg::REQ_SIGN: begin
                o_cmd.data = ssld_pkg::seg_code(i_in_item.sign_char);
            end
            ssld_pkg::REQ_SIGN_DOT: begin
                o_cmd.data = ssld_pkg::seg_code({i_in_item.dot_flag,
                                                 i_in_item.sign_char[6:0]});
            end
            ssld_pkg::REQ_SIGN_EXP: begin
                o_cmd.data = {i_in_item.dot_flag,
                              7'(ssld_pkg::seg_code(i_in_item.sign_char))};
            end
            ssld_pkg::REQ_DIGIT: begin
                if (i_in_item.digit_value >= 8'd10) begin
                    o_cmd.data = ssld_pkg::seg_code(ssld_pkg::CHAR_AT);
                end else begin
                    o_cmd.data = ssld_pkg::seg_code(ssld_pkg::CHAR_ZERO
                                                    + i_in_item.digit_value);
                end
            end
            ssld_pkg::REQ_CLEAR: begin
                o_cmd.reps = 3'(len_clamped - 4'd1);
            end
            ssld_pkg::REQ_DOTS: begin
                o_cmd.op   = ssld_pkg::CMD_DOTS;
                o_cmd.data = i_in_item.dot_mask;
            end
            default: begin
                is_cmd = 1'b0;
            end
        endcase
    end

    assign o_in_ready  = i_cmd_ready;
    assign o_cmd_valid = i_in_valid && is_cmd;

endmodule

@@ rtl/ssld_fifo.sv @@
module ssld_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  ssld_pkg::t_cmd i_wr_cmd,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output ssld_pkg::t_cmd o_rd_cmd
);

    ssld_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           wr_en;
    logic           rd_en;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_cmd   = r_mem[r_rp];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr_en) - 2'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

endmodule

@@ rtl/ssld_back.sv @@
module ssld_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  ssld_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssld_pkg::t_out_item o_out_item
);

    logic [63:0]         r_shadow, n_shadow;
    logic [63:0]         r_sh, n_sh;
    logic [7:0]          r_data, n_data;
    logic [2:0]          r_bytes, n_bytes;
    logic [6:0]          r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    ssld_pkg::t_out_item r_out, n_out;
    logic                can_load;
    logic                fin;
    logic [63:0]         dots_line;

    assign can_load    = !r_out_valid || i_out_ready;
    assign o_cmd_ready = can_load && (r_cnt == 7'd0);
    assign dots_line   = ssld_pkg::dots_overlay(r_shadow, i_cmd.data);
    assign fin         = (r_cnt == 7'd1) && (r_bytes == 3'd0);

    always_comb begin
        n_shadow    = r_shadow;
        n_sh        = r_sh;
        n_data      = r_data;
        n_bytes     = r_bytes;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (can_load) begin
            n_out_valid = 1'b0;
            if (r_cnt != 7'd0) begin
                n_out_valid       = 1'b1;
                n_out.serial_bit  = r_sh[63];
                n_out.latch_pulse = fin;
                n_out.last        = fin;
                n_sh              = {r_sh[62:0], 1'b0};
                n_cnt             = r_cnt - 7'd1;
                if (r_cnt == 7'd1 && r_bytes != 3'd0) begin
                    n_shadow = {r_shadow[55:0], r_data};
                    n_sh     = {r_data, 56'b0};
                    n_cnt    = 7'd8;
                    n_bytes  = r_bytes - 3'd1;
                end
            end else if (i_cmd_valid) begin
                if (i_cmd.op == ssld_pkg::CMD_PUSH) begin
                    n_shadow = {r_shadow[55:0], i_cmd.data};
                    n_sh     = {i_cmd.data, 56'b0};
                    n_cnt    = 7'd8;
                    n_bytes  = i_cmd.reps;
                    n_data   = i_cmd.data;
                end else begin
                    n_shadow = dots_line;
                    n_sh     = dots_line;
                    n_cnt    = 7'd64;
                    n_bytes  = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= 64'd0;
            r_bytes     <= 3'd0;
            r_cnt       <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_shadow    <= n_shadow;
            r_bytes     <= n_bytes;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'd64)
        else $error("bit counter out of range");

    a_bytes_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes != 3'd0 |-> r_cnt != 7'd0)
        else $error("bytes pending outside a run");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && o_cmd_ready) |=> r_cnt != 7'd0)
        else $error("command taken without starting a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (can_load && r_cnt != 7'd0 && fin) |=> (r_cnt == 7'd0 && r_out.last))
        else $error("final bit did not close the run");
`endif

endmodule

@@ rtl/seven_segment_line_driver.sv @@
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_ready    i_in_item  (ssld_pkg::t_in_item)
// out       o_out_valid / i_out_ready  o_out_item (ssld_pkg::t_out_item)
// config    i_cfg_we                   i_cfg_data (line_length)
//
// A character, digit or dot request starts a run in the serializer, then shifts its
// eight bits. Clear shifts eight bits per digit of the clamped line_length, and dots
// the whole 64-bit line, all through the one-bit-per-cycle serializer unless stalled.
// A two-entry command queue lets new requests be accepted while a run is shifting.
// Reset clears the shadow line and sets line_length to 8.
// A stalled output holds its bit and pauses the serializer.
module seven_segment_line_driver #(
    parameter int MAX_DIGITS = ssld_pkg::MAX_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssld_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssld_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data
);

    logic           fq_valid;
    logic           fq_ready;
    ssld_pkg::t_cmd fq_cmd;
    logic           qb_valid;
    logic           qb_ready;
    ssld_pkg::t_cmd qb_cmd;

    ssld_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (fq_valid),
        .i_cmd_ready (fq_ready),
        .o_cmd       (fq_cmd)
    );

    ssld_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_cmd   (fq_cmd),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_cmd   (qb_cmd)
    );

    ssld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (qb_valid),
        .o_cmd_ready (qb_ready),
        .i_cmd       (qb_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ tb/ssld_checker.sv @@
module ssld_checker #(
    parameter int MAX_DIGITS = ssld_pkg::MAX_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ssld_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ssld_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_bit_count,
    output int                  o_request_count
);

    localparam int FIRST_GLYPH_CODE = 33;
    localparam int LAST_GLYPH_INDEX = 68;

    localparam logic [8*69-1:0] GLYPH_ROM = {
        8'hC8, 8'h0A, 8'h7F, 8'h6E, 8'h99, 8'h3F, 8'h00, 8'h16, 8'h4C, 8'h2B, 8'h49, 8'h40,
        8'h01, 8'h80, 8'h19, 8'h7E, 8'h48, 8'h3D, 8'h6D, 8'h4B, 8'h67, 8'h77, 8'h4C, 8'h7F,
        8'h6F, 8'h81, 8'hC0, 8'h39, 8'h21, 8'h63, 8'h9D, 8'h5D, 8'h5F, 8'h73, 8'h31, 8'h79,
        8'h37, 8'h17, 8'h76, 8'h53, 8'h12, 8'h78, 8'h3B, 8'h32, 8'h5E, 8'h51, 8'h71, 8'h1F,
        8'h4F, 8'h57, 8'h66, 8'h4C, 8'h70, 8'h2A, 8'h7A, 8'h5B, 8'h6B, 8'h3C, 8'h36, 8'h43,
        8'h6C, 8'h0E, 8'h20, 8'h08, 8'h27, 8'h5A, 8'h2D, 8'h75, 8'h0F
    };

    logic [63:0]         shadow_line;
    logic [3:0]          line_length;
    ssld_pkg::t_out_item expected_bits[$];

    function automatic logic [7:0] glyph_for(input logic [7:0] ch);
        int         code;
        logic [7:0] flip;
        code = int'(ch[6:0]);
        flip = {ch[7], 7'b0};
        if (code == int'(ssld_pkg::CHAR_LF) || code == int'(ssld_pkg::CHAR_SP)) begin
            return 8'h00;
        end
        if (code < FIRST_GLYPH_CODE) begin
            return 8'hFF ^ flip;
        end
        // Lowercase folds onto uppercase; the five codes after 'z' use the table tail.
        if (code > 96) begin
            if (code > 122) begin
                code = code + 6;
            end
            code = code - 32;
        end
        code = code - FIRST_GLYPH_CODE;
        if (code > LAST_GLYPH_INDEX) begin
            code = LAST_GLYPH_INDEX;
        end
        return GLYPH_ROM[8*(LAST_GLYPH_INDEX - code) +: 8] ^ flip;
    endfunction

    task automatic push_bit(input logic value, input logic strobe);
        ssld_pkg::t_out_item b;
        b.serial_bit  = value;
        b.latch_pulse = strobe;
        b.last        = strobe;
        expected_bits.push_back(b);
    endtask

    task automatic push_glyph(input logic [7:0] glyph, input logic strobe);
        shadow_line = {shadow_line[55:0], glyph};
        for (int s = 7; s >= 0; s--) begin
            push_bit(glyph[s], strobe && s == 0);
        end
    endtask

    task automatic predict_request(input ssld_pkg::t_in_item req);
        logic [7:0] glyph;
        int         digits;
        case (req.req_type)
            ssld_pkg::REQ_SIGN: begin
                push_glyph(glyph_for(req.sign_char), 1'b1);
            end
            ssld_pkg::REQ_SIGN_DOT: begin
                push_glyph(glyph_for({req.dot_flag, req.sign_char[6:0]}), 1'b1);
            end
            ssld_pkg::REQ_SIGN_EXP: begin
                glyph = glyph_for(req.sign_char);
                push_glyph({req.dot_flag, glyph[6:0]}, 1'b1);
            end
            ssld_pkg::REQ_DIGIT: begin
                glyph = (req.digit_value >= 8'd10) ? ssld_pkg::CHAR_AT
                                                   : ssld_pkg::CHAR_ZERO + req.digit_value;
                push_glyph(glyph_for(glyph), 1'b1);
            end
            ssld_pkg::REQ_CLEAR: begin
                digits = int'(line_length);
                if (digits < 1) begin
                    digits = 1;
                end
                if (digits > MAX_DIGITS) begin
                    digits = MAX_DIGITS;
                end
                for (int i = 0; i < digits; i++) begin
                    push_glyph(8'h00, i == digits - 1);
                end
            end
            ssld_pkg::REQ_DOTS: begin
                for (int i = 0; i < 8; i++) begin
                    shadow_line[8*i + 7] = req.dot_mask[i];
                end
                for (int i = 63; i >= 0; i--) begin
                    push_bit(shadow_line[i], i == 0);
                end
            end
            default: begin
                return;
            end
        endcase
        o_request_count++;
    endtask

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("mismatch on bit %0d: %s", o_bit_count, msg);
    endtask

    task automatic check_bit(input ssld_pkg::t_out_item got);
        ssld_pkg::t_out_item want;
        if (expected_bits.size() == 0) begin
            report_mismatch("output transfer with no bit expected");
        end else begin
            want = expected_bits.pop_front();
            if (got.serial_bit !== want.serial_bit) begin
                report_mismatch($sformatf("serial_bit %b, expected %b",
                                          got.serial_bit, want.serial_bit));
            end
            if (got.latch_pulse !== want.latch_pulse) begin
                report_mismatch($sformatf("latch_pulse %b, expected %b",
                                          got.latch_pulse, want.latch_pulse));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            end
        end
        o_bit_count++;
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_bit_count     = 0;
        o_request_count = 0;
        shadow_line     = '0;
        line_length     = 4'd8;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_line = '0;
            line_length = 4'd8;
            expected_bits.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_bit(i_out_item);
            end
            if (i_cfg_we) begin
                line_length = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(i_in_item);
            end
        end
        o_pending = expected_bits.size();
    end

endmodule

@@ tb/seven_segment_line_driver_test.sv @@
module seven_segment_line_driver_test;

    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 50;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    ssld_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready = 1'b0;
    ssld_pkg::t_out_item out_item;
    logic                cfg_we;
    logic [3:0]          cfg_data;
    logic                quiet = 1'b0;

    int fail_count;
    int pending;
    int bit_count;
    int request_count;
    int ignored_count = 0;
    int cfg_writes = 0;
    int stall_cycles = 0;

    seven_segment_line_driver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    ssld_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_item     (out_item),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bit_count    (bit_count),
        .o_request_count(request_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 32);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d bits still expected",
                     STALL_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic ssld_pkg::t_in_item make_request(input logic [2:0] op,
                                                        input logic [7:0] ch,
                                                        input logic dot,
                                                        input logic [7:0] digit,
                                                        input logic [7:0] mask);
        ssld_pkg::t_in_item r;
        r.req_type    = op;
        r.sign_char   = ch;
        r.dot_flag    = dot;
        r.digit_value = digit;
        r.dot_mask    = mask;
        return r;
    endfunction

    function automatic ssld_pkg::t_in_item random_request();
        ssld_pkg::t_in_item r;
        int                 pick;
        r.sign_char   = 8'($urandom);
        r.dot_flag    = 1'($urandom);
        r.digit_value = 8'($urandom);
        r.dot_mask    = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 3) begin
            r.req_type = (pick == 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
        end else if (pick < 22) begin
            r.req_type = ssld_pkg::REQ_SIGN;
        end else if (pick < 38) begin
            r.req_type = ssld_pkg::REQ_SIGN_DOT;
        end else if (pick < 54) begin
            r.req_type = ssld_pkg::REQ_SIGN_EXP;
        end else if (pick < 72) begin
            r.req_type = ssld_pkg::REQ_DIGIT;
        end else if (pick < 86) begin
            r.req_type = ssld_pkg::REQ_CLEAR;
        end else begin
            r.req_type = ssld_pkg::REQ_DOTS;
        end
        case ($urandom_range(5))
            1: r.sign_char = {r.sign_char[7], 7'($urandom_range(32))};
            2: r.sign_char = {r.sign_char[7], 7'($urandom_range(122, 97))};
            3: r.sign_char = {r.sign_char[7], 7'($urandom_range(127, 123))};
            4: r.sign_char = {r.sign_char[7],
                              $urandom_range(1) ? ssld_pkg::CHAR_LF[6:0]
                                                : ssld_pkg::CHAR_SP[6:0]};
            5: r.sign_char = {r.sign_char[7], 7'($urandom_range(96, 33))};
            default: ;
        endcase
        if ($urandom_range(9) < 7) begin
            r.digit_value = 8'($urandom_range(9));
        end
        return r;
    endfunction

    task automatic send_request(input ssld_pkg::t_in_item req);
        if (!quiet && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 32) begin
                @(posedge clk);
            end
        end
        in_item  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        if (req.req_type == REQ_UNUSED_A || req.req_type == REQ_UNUSED_B) begin
            ignored_count++;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_line_length(input logic [3:0] len);
        cfg_data <= len;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        ssld_pkg::t_in_item req;
        int                 counted;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(ssld_pkg::REQ_CLEAR, 8'h00, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'h41, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'hC1, 1'b1, 8'hFF, 8'hFF));
        send_request(make_request(ssld_pkg::REQ_SIGN, ssld_pkg::CHAR_LF, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'h8A, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, ssld_pkg::CHAR_SP, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'h00, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'h80, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'h21, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'h7A, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'h7B, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN, 8'hFF, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN_DOT, 8'h41, 1'b1, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN_DOT, 8'hC1, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN_EXP, ssld_pkg::CHAR_ZERO, 1'b1,
                                  8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_SIGN_EXP, 8'h80, 1'b0, 8'h00, 8'h00));
        send_request(make_request(ssld_pkg::REQ_DIGIT, 8'h00, 1'b0, 8'd0, 8'h00));
        send_request(make_request(ssld_pkg::REQ_DIGIT, 8'h00, 1'b0, 8'd9, 8'h00));
        send_request(make_request(ssld_pkg::REQ_DIGIT, 8'h00, 1'b0, 8'd10, 8'h00));
        send_request(make_request(ssld_pkg::REQ_DIGIT, 8'h00, 1'b0, 8'd255, 8'h00));
        send_request(make_request(ssld_pkg::REQ_DOTS, 8'h00, 1'b0, 8'h00, 8'hFF));
        send_request(make_request(ssld_pkg::REQ_DOTS, 8'h00, 1'b0, 8'h00, 8'h00));
        send_request(make_request(REQ_UNUSED_A, 8'h41, 1'b1, 8'h05, 8'h3C));
        send_request(make_request(REQ_UNUSED_B, 8'h41, 1'b1, 8'h05, 8'h3C));
        send_request(make_request(ssld_pkg::REQ_DOTS, 8'h00, 1'b0, 8'h00, 8'hA5));

        wait_idle();
        set_line_length(4'd0);
        send_request(make_request(ssld_pkg::REQ_CLEAR, 8'h00, 1'b0, 8'h00, 8'h00));
        wait_idle();
        set_line_length(4'd15);
        send_request(make_request(ssld_pkg::REQ_CLEAR, 8'h00, 1'b0, 8'h00, 8'h00));
        wait_idle();
        set_line_length(4'd1);
        send_request(make_request(ssld_pkg::REQ_CLEAR, 8'h00, 1'b0, 8'h00, 8'h00));

        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: set_line_length(4'd3);
                1: set_line_length(4'd8);
                2: set_line_length(4'd12);
                3: set_line_length(4'd6);
                default: set_line_length(4'($urandom_range(15)));
            endcase
            quiet <= (phase == 2);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                req = random_request();
                send_request(req);
                if (req.req_type != REQ_UNUSED_A && req.req_type != REQ_UNUSED_B) begin
                    counted++;
                end
            end
        end

        wait_idle();
        repeat (80) @(posedge clk);
        $display("Run covered %0d segment requests (%0d unused codes) under %0d line lengths.",
                 request_count, ignored_count, cfg_writes + 1);
        $display("%0d serialized bits were compared, %0d mismatches found.",
                 bit_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ssld_pkg.sv
rtl/ssld_front.sv
rtl/ssld_fifo.sv
rtl/ssld_back.sv
rtl/seven_segment_line_driver.sv
tb/ssld_checker.sv
tb/seven_segment_line_driver_test.sv
